[sv/psu_pkg.sv]
// Shared types, register indexes and filter helpers for the PNG scanline unfilter.
package psu_pkg;

  typedef enum logic [1:0] {
    REG_BPP    = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filt_t;

  typedef struct packed {
    logic  first_row;
    logic  sol;
    filt_t filt;
    logic  row_end;
    logic  image_end;
  } item_flags_t;

  function automatic filt_t filt_decode(input logic [7:0] b);
    filt_t f;
    if (b <= 8'(FILT_PAETH)) f = filt_t'(b[2:0]);
    else f = FILT_BAD;
    return f;
  endfunction

  function automatic logic [9:0] abs10(input logic signed [9:0] v);
    logic [9:0] r;
    r = (v < 0) ? 10'(-v) : 10'(v);
    return r;
  endfunction

  function automatic logic [7:0] paeth(input logic [7:0] l, input logic [7:0] u,
                                       input logic [7:0] ul);
    logic signed [9:0] sl, su, sul;
    logic [9:0] dl, du, dul;
    logic [7:0] r;
    sl  = $signed({2'b00, l});
    su  = $signed({2'b00, u});
    sul = $signed({2'b00, ul});
    // distances of the estimate l+u-ul to each neighbour
    dl  = abs10(su - sul);
    du  = abs10(sl - sul);
    dul = abs10(sl + su - sul - sul);
    if (dl <= du && dl <= dul) r = l;
    else if (du <= dul) r = u;
    else r = ul;
    return r;
  endfunction

endpackage

[sv/png_scanline_unfilter.sv]
// PNG scanline unfilter top level: configuration registers, front end, queue, back end.
// Path: a row byte accepted at the input is queued, held in back-end stage A, then registered
// on out_valid; a filter byte gives no result.
// Throughput: one byte per cycle while out_stall is low, set by the left-neighbour recurrence
// in the back end (reconstruct, write line store and history in the same cycle).
// Reset: control and configuration return to defaults (3 bytes/pixel, width 1, height 1);
// the line store is not cleared and needs no clearing pass.
module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES   = 16384,
  parameter int MAX_PIXEL_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_byte,
  output logic        out_row_end,
  output logic        out_image_end,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import psu_pkg::*;

  localparam int LW  = $clog2(MAX_ROW_BYTES + 1);
  localparam int AW  = $clog2(MAX_ROW_BYTES);
  localparam int PW  = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int IW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int PRW = 13 + PW;
  localparam int FW  = $bits(item_flags_t);
  localparam int DW  = FW + 8 + AW;

  logic [2:0]   bpp_r;
  logic [12:0]  width_r;
  logic [15:0]  height_r;

  logic [PW-1:0]  pix_size;
  logic [12:0]    width_eff;
  logic [PRW-1:0] row_prod;
  logic [LW-1:0]  row_len;
  logic [IW-1:0]  left_sel;

  logic          q_push, q_full, q_pop, q_not_empty;
  logic [7:0]    push_byte, pop_byte;
  logic [AW-1:0] push_addr, pop_addr;
  item_flags_t   push_flags, pop_flags;
  logic [DW-1:0] push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= 3'd3;
      width_r  <= 13'd1;
      height_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BPP:    bpp_r    <= cfg_data[2:0];
        REG_WIDTH:  width_r  <= cfg_data[12:0];
        REG_HEIGHT: height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // pixel size clamped to 1..MAX_PIXEL_BYTES, row length saturated to the store
  always_comb begin
    if (bpp_r == 3'd0) pix_size = PW'(1);
    else if (32'(bpp_r) > 32'(MAX_PIXEL_BYTES)) pix_size = PW'(MAX_PIXEL_BYTES);
    else pix_size = PW'(bpp_r);
    width_eff = (width_r == 13'd0) ? 13'd1 : width_r;
    row_prod  = PRW'(width_eff) * PRW'(pix_size);
    row_len   = (32'(row_prod) > 32'(MAX_ROW_BYTES)) ? LW'(MAX_ROW_BYTES) : LW'(row_prod);
    left_sel  = IW'(pix_size - PW'(1));
  end

  psu_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .row_len        (row_len),
    .height         (height_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_byte         (push_byte),
    .q_addr         (push_addr),
    .q_flags        (push_flags)
  );

  assign push_data = {push_flags, push_byte, push_addr};

  psu_fifo #(
    .DW (DW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  assign pop_flags = item_flags_t'(pop_data[DW-1 -: FW]);
  assign pop_byte  = pop_data[AW +: 8];
  assign pop_addr  = pop_data[AW-1:0];

  psu_back #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_not_empty),
    .q_pop          (q_pop),
    .q_byte         (pop_byte),
    .q_addr         (pop_addr),
    .q_flags        (pop_flags),
    .left_sel       (left_sel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_byte (out_pixel_byte),
    .out_row_end    (out_row_end),
    .out_image_end  (out_image_end),
    .out_status     (out_status)
  );

  a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_row_end)
    else $error("image end without row end");

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");

  a_pop_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("pop from empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("not idle after reset");

endmodule

[sv/psu_front.sv]
// Front end: takes stream bytes, tracks filter bytes, columns and rows.
module psu_front #(
  parameter int MAX_ROW_BYTES = 16384
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             in_stream_byte,
  input  logic [$clog2(MAX_ROW_BYTES+1)-1:0]     row_len,
  input  logic [15:0]                            height,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [7:0]                             q_byte,
  output logic [$clog2(MAX_ROW_BYTES)-1:0]       q_addr,
  output psu_pkg::item_flags_t                   q_flags
);
  import psu_pkg::*;

  localparam int LW = $clog2(MAX_ROW_BYTES + 1);
  localparam int AW = $clog2(MAX_ROW_BYTES);

  logic          awaiting_r, awaiting_nxt;
  logic          sol_r, sol_nxt;
  filt_t         filt_r, filt_nxt;
  logic [LW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;

  logic          accept;
  logic [LW-1:0] col_inc;
  logic [15:0]   height_eff;
  logic          row_end, image_end;

  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign col_inc    = col_r + LW'(1);
  assign height_eff = (height == 16'd0) ? 16'd1 : height;
  assign row_end    = (col_inc >= row_len);
  assign image_end  = row_end && ((17'(row_r) + 17'd1) >= 17'(height_eff));

  assign q_push  = accept && !awaiting_r;
  assign q_byte  = in_stream_byte;
  assign q_addr  = col_r[AW-1:0];
  assign q_flags = '{first_row: (row_r == 16'd0), sol: sol_r, filt: filt_r,
                     row_end: row_end, image_end: image_end};

  always_comb begin
    awaiting_nxt = awaiting_r;
    sol_nxt      = sol_r;
    filt_nxt     = filt_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (accept) begin
      if (awaiting_r) begin
        filt_nxt     = filt_decode(in_stream_byte);
        awaiting_nxt = 1'b0;
        sol_nxt      = 1'b1;
        col_nxt      = '0;
      end else begin
        sol_nxt = 1'b0;
        col_nxt = col_inc;
        if (row_end) begin
          awaiting_nxt = 1'b1;
          col_nxt      = '0;
          row_nxt      = image_end ? 16'd0 : row_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b1;
      sol_r      <= 1'b1;
      filt_r     <= FILT_NONE;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      awaiting_r <= awaiting_nxt;
      sol_r      <= sol_nxt;
      filt_r     <= filt_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

endmodule

[sv/psu_fifo.sv]
// Two-entry queue between the front end and the reconstruction back end.
module psu_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] pop_data
);

  logic [DW-1:0] slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

[sv/psu_back.sv]
// Back end: line store read, filter reconstruction and output register.
module psu_back #(
  parameter int MAX_ROW_BYTES   = 16384,
  parameter int MAX_PIXEL_BYTES = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_valid,
  output logic                                   q_pop,
  input  logic [7:0]                             q_byte,
  input  logic [$clog2(MAX_ROW_BYTES)-1:0]       q_addr,
  input  psu_pkg::item_flags_t                   q_flags,
  input  logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] left_sel,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [7:0]                             out_pixel_byte,
  output logic                                   out_row_end,
  output logic                                   out_image_end,
  output logic                                   out_status
);
  import psu_pkg::*;

  localparam int AW = $clog2(MAX_ROW_BYTES);

  logic [7:0]  line_mem [MAX_ROW_BYTES];

  logic          a_valid_r;
  logic [7:0]    a_byte_r;
  logic [AW-1:0] a_addr_r;
  item_flags_t   a_flags_r;
  logic [7:0]    rd_data_r;
  logic          fwd_r;
  logic [7:0]    fwd_data_r;

  logic [7:0]    cur_hist_r [MAX_PIXEL_BYTES];
  logic [7:0]    up_hist_r  [MAX_PIXEL_BYTES];
  logic [7:0]    cur_eff    [MAX_PIXEL_BYTES];
  logic [7:0]    up_eff     [MAX_PIXEL_BYTES];

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_row_end_r, out_image_end_r, out_status_r;

  logic          out_free, a_go;
  logic [7:0]    up, left, upleft, val;
  logic [8:0]    avg_sum;

  assign out_free = !out_valid_r || !out_stall;
  assign a_go     = a_valid_r && out_free;
  assign q_pop    = q_valid && (!a_valid_r || out_free);

  // a new row starts its neighbour history from zero
  always_comb begin
    for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
      cur_eff[i] = a_flags_r.sol ? 8'd0 : cur_hist_r[i];
      up_eff[i]  = a_flags_r.sol ? 8'd0 : up_hist_r[i];
    end
  end

  always_comb begin
    up      = a_flags_r.first_row ? 8'd0 : (fwd_r ? fwd_data_r : rd_data_r);
    left    = cur_eff[left_sel];
    upleft  = up_eff[left_sel];
    avg_sum = 9'(left) + 9'(up);
    case (a_flags_r.filt)
      FILT_NONE:  val = a_byte_r;
      FILT_SUB:   val = a_byte_r + left;
      FILT_UP:    val = a_byte_r + up;
      FILT_AVG:   val = a_byte_r + avg_sum[8:1];
      FILT_PAETH: val = a_byte_r + paeth(left, up, upleft);
      default:    val = a_byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) a_valid_r <= 1'b1;
      else if (a_go) a_valid_r <= 1'b0;
      if (a_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // stage A payload; a same-address write in flight is forwarded past the store
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_byte_r   <= q_byte;
      a_addr_r   <= q_addr;
      a_flags_r  <= q_flags;
      rd_data_r  <= line_mem[q_addr];
      fwd_r      <= a_go && (a_addr_r == q_addr);
      fwd_data_r <= val;
    end
    if (a_go) line_mem[a_addr_r] <= val;
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        cur_hist_r[i] <= cur_eff[i-1];
        up_hist_r[i]  <= up_eff[i-1];
      end
      cur_hist_r[0]   <= val;
      up_hist_r[0]    <= up;
      out_byte_r      <= val;
      out_row_end_r   <= a_flags_r.row_end;
      out_image_end_r <= a_flags_r.image_end;
      out_status_r    <= (a_flags_r.filt == FILT_BAD);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_byte = out_byte_r;
  assign out_row_end    = out_row_end_r;
  assign out_image_end  = out_image_end_r;
  assign out_status     = out_status_r;

endmodule
